FILE: rtl/rpt_pkg.sv
// Shared types and constants for the row permutation tracker.
`default_nettype none
package rpt_pkg;

    localparam int ADR_W        = 9;
    localparam int IDX_W        = 8;
    localparam int VAL_W        = 8;
    localparam int MAX_ROWS_DEF = 256;

    localparam logic [ADR_W-1:0] SIZE_RESET = 9'd256;

    localparam logic [1:0] FN_CLEAR   = 2'd0;
    localparam logic [1:0] FN_SWAP    = 2'd1;
    localparam logic [1:0] FN_COMPOSE = 2'd2;
    localparam logic [1:0] FN_READ    = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SWAP,
        OP_COMPOSE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             err;
        logic [ADR_W-1:0] a;
        logic [ADR_W-1:0] b;
        logic [ADR_W-1:0] count;
        logic [IDX_W-1:0] slot;
        logic             last;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/row_permutation_tracker.sv
// Row permutation tracker top level: front end, command queue and back end.
// Per item: an error goes straight to the result; read, swap and compose use the table memory,
//   compose with a write-back of the sub-permutation on the last item; clear walks the active size.
// Queue holds two items, so the front accepts while the back is busy.
// Output register frees the back from a stalled consumer.
// Reset: table initialized to identity by a walk over all MAX_ROWS rows; no items taken meanwhile.
`default_nettype none
module row_permutation_tracker #(
    parameter int MAX_ROWS = rpt_pkg::MAX_ROWS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [rpt_pkg::ADR_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                func,
    input  wire logic [rpt_pkg::IDX_W-1:0] index,
    input  wire logic [rpt_pkg::IDX_W-1:0] target,
    input  wire logic [rpt_pkg::ADR_W-1:0] sub_length,
    input  wire logic                      last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [rpt_pkg::VAL_W-1:0]      read_value,
    output logic                           range_error,
    output logic                           done_res
);
    import rpt_pkg::*;

    logic init_busy;
    logic push_ready;
    logic push_valid;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop;
    cmd_t head_cmd;

    rpt_front #(
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .index      (index),
        .target     (target),
        .sub_length (sub_length),
        .last       (last),
        .init_busy  (init_busy),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    rpt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .head_cmd   (head_cmd)
    );

    rpt_back #(
        .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop         (pop),
        .head_cmd    (head_cmd),
        .init_busy   (init_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .range_error (range_error),
        .done_res    (done_res)
    );

endmodule
`default_nettype wire

FILE: rtl/rpt_front.sv
// Front end: size register, range checks and command build for each item.
`default_nettype none
module rpt_front #(
    parameter int MAX_ROWS = rpt_pkg::MAX_ROWS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [rpt_pkg::ADR_W-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               func,
    input  wire logic [rpt_pkg::IDX_W-1:0] index,
    input  wire logic [rpt_pkg::IDX_W-1:0] target,
    input  wire logic [rpt_pkg::ADR_W-1:0] sub_length,
    input  wire logic                     last,
    input  wire logic                     init_busy,
    input  wire logic                     push_ready,
    output logic                          push_valid,
    output rpt_pkg::cmd_t                 push_cmd
);
    import rpt_pkg::*;

    localparam int CAP = (MAX_ROWS < 511) ? MAX_ROWS : 511;
    localparam logic [ADR_W-1:0] SIZE_CAP = ADR_W'(CAP);

    logic [ADR_W-1:0] active_size_reg;
    logic [ADR_W-1:0] size;
    logic [ADR_W-1:0] idx_w;
    logic [ADR_W-1:0] tgt_w;
    logic [ADR_W-1:0] begin_pos;

    assign cfg_ready  = 1'b1;
    assign in_ready   = !init_busy && push_ready;
    assign push_valid = in_valid && in_ready;

    assign size      = (active_size_reg > SIZE_CAP) ? SIZE_CAP : active_size_reg;
    assign idx_w     = {1'b0, index};
    assign tgt_w     = {1'b0, target};
    assign begin_pos = size - sub_length;

    always_comb
    begin
        push_cmd.op    = OP_CLEAR;
        push_cmd.err   = 1'b0;
        push_cmd.a     = idx_w;
        push_cmd.b     = tgt_w;
        push_cmd.count = size;
        push_cmd.slot  = index;
        push_cmd.last  = last;
        case (func)
            FN_CLEAR:
            begin
                push_cmd.op = OP_CLEAR;
            end
            FN_SWAP:
            begin
                push_cmd.op  = OP_SWAP;
                push_cmd.err = (idx_w >= size) || (tgt_w >= size);
            end
            FN_COMPOSE:
            begin
                push_cmd.op    = OP_COMPOSE;
                push_cmd.err   = (sub_length == '0) || (sub_length > size) ||
                                 (idx_w >= sub_length) || (tgt_w >= sub_length);
                push_cmd.a     = begin_pos + tgt_w;
                push_cmd.b     = begin_pos;
                push_cmd.count = sub_length;
            end
            FN_READ:
            begin
                push_cmd.op  = OP_READ;
                push_cmd.err = (idx_w >= size);
            end
            default:
            begin
                push_cmd.op = OP_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_size_reg <= SIZE_RESET;
        else if (cfg_valid && cfg_ready)
            active_size_reg <= cfg_data;
    end

endmodule
`default_nettype wire

FILE: rtl/rpt_fifo.sv
// Two-entry command queue between front and back.
`default_nettype none
module rpt_fifo (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire rpt_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  wire logic      pop,
    output rpt_pkg::cmd_t  head_cmd
);
    import rpt_pkg::*;

    cmd_t       slots_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign head_cmd   = slots_reg[rd_ptr_reg];
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_valid && push_ready)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if ((push_valid && push_ready) && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (!(push_valid && push_ready) && do_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rpt_back.sv
// Back end: table and compose buffer memories, operation sequencer, result register.
`default_nettype none
module rpt_back #(
    parameter int MAX_ROWS = rpt_pkg::MAX_ROWS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pop_valid,
    output logic                           pop,
    input  wire rpt_pkg::cmd_t             head_cmd,
    output logic                           init_busy,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [rpt_pkg::VAL_W-1:0]      read_value,
    output logic                           range_error,
    output logic                           done_res
);
    import rpt_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (AW > ADR_W) ? AW : ADR_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_SW1,
        S_SW2,
        S_SW3,
        S_CP1,
        S_WBR,
        S_WB,
        S_RD1,
        S_DONE
    } state_t;

    logic [AW-1:0] tbl_mem [MAX_ROWS];
    logic [AW-1:0] buf_mem [MAX_ROWS];
    logic [AW-1:0] tbl_rd_reg;
    logic [AW-1:0] buf_rd_reg;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    hold_reg, hold_next;
    logic [VAL_W-1:0] pend_val_reg, pend_val_next;
    logic             pend_err_reg, pend_err_next;
    logic             res_valid_reg, res_valid_next;
    logic [VAL_W-1:0] res_val_reg, res_val_next;
    logic             res_err_reg, res_err_next;

    logic             tbl_we;
    logic [AW-1:0]    tbl_wa;
    logic [AW-1:0]    tbl_wd;
    logic [AW-1:0]    tbl_ra;
    logic             buf_we;
    logic [AW-1:0]    buf_ra;
    logic [ADR_W-1:0] wb_pos;
    logic [CW-1:0]    end_cnt;

    assign init_busy   = (state_reg == S_INIT);
    assign out_valid   = res_valid_reg;
    assign read_value  = res_val_reg;
    assign range_error = res_err_reg;
    assign done_res    = 1'b1;
    assign pop         = (state_reg == S_IDLE) && pop_valid;
    assign wb_pos      = cmd_reg.b + ADR_W'(cnt_reg);
    assign end_cnt     = CW'(cmd_reg.count - 9'd1);

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_wa] <= tbl_wd;
        tbl_rd_reg <= tbl_mem[tbl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[AW'(cmd_reg.slot)] <= tbl_rd_reg;
        buf_rd_reg <= buf_mem[buf_ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        hold_next      = hold_reg;
        pend_val_next  = pend_val_reg;
        pend_err_next  = pend_err_reg;
        res_valid_next = res_valid_reg;
        res_val_next   = res_val_reg;
        res_err_next   = res_err_reg;
        tbl_we         = 1'b0;
        tbl_wa         = AW'(cnt_reg);
        tbl_wd         = AW'(cnt_reg);
        tbl_ra         = AW'(cmd_reg.a);
        buf_we         = 1'b0;
        buf_ra         = AW'(cnt_reg);

        if (res_valid_reg && out_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                tbl_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MAX_ROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                tbl_ra = AW'(head_cmd.a);
                if (pop_valid)
                begin
                    cmd_next      = head_cmd;
                    cnt_next      = '0;
                    pend_val_next = '0;
                    pend_err_next = head_cmd.err;
                    if (head_cmd.err)
                        state_next = S_DONE;
                    else
                    begin
                        case (head_cmd.op)
                            OP_CLEAR:
                                state_next = (head_cmd.count == '0) ? S_DONE : S_CLR;
                            OP_SWAP:    state_next = S_SW1;
                            OP_COMPOSE: state_next = S_CP1;
                            OP_READ:    state_next = S_RD1;
                            default:    state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_CLR:
            begin
                tbl_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == end_cnt)
                    state_next = S_DONE;
            end
            S_SW1:
            begin
                tbl_ra     = AW'(cmd_reg.b);
                hold_next  = tbl_rd_reg;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                tbl_we     = 1'b1;
                tbl_wa     = AW'(cmd_reg.a);
                tbl_wd     = tbl_rd_reg;
                state_next = S_SW3;
            end
            S_SW3:
            begin
                tbl_we     = 1'b1;
                tbl_wa     = AW'(cmd_reg.b);
                tbl_wd     = hold_reg;
                state_next = S_DONE;
            end
            S_CP1:
            begin
                buf_we     = 1'b1;
                cnt_next   = '0;
                state_next = cmd_reg.last ? S_WBR : S_DONE;
            end
            S_WBR:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                tbl_we = 1'b1;
                tbl_wa = AW'(wb_pos);
                tbl_wd = buf_rd_reg;
                buf_ra = AW'(cnt_reg + CW'(1));
                if (cnt_reg == end_cnt)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_RD1:
            begin
                pend_val_next = VAL_W'(tbl_rd_reg);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || out_ready)
                begin
                    res_valid_next = 1'b1;
                    res_val_next   = pend_val_reg;
                    res_err_next   = pend_err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            hold_reg      <= '0;
            pend_val_reg  <= '0;
            pend_err_reg  <= 1'b0;
            res_val_reg   <= '0;
            res_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            cmd_reg       <= cmd_next;
            hold_reg      <= hold_next;
            pend_val_reg  <= pend_val_next;
            pend_err_reg  <= pend_err_next;
            res_val_reg   <= res_val_next;
            res_err_reg   <= res_err_next;
        end
    end

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_INIT |=> state_reg != S_INIT)
        else $error("sequencer returned to table init");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result loaded outside done state");

    a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> cnt_reg <= end_cnt)
        else $error("clear walk ran past active size");

    a_wb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB |-> cnt_reg <= end_cnt)
        else $error("write-back ran past sub-permutation length");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != S_IDLE)
        else $error("item popped but sequencer stayed idle");

endmodule
`default_nettype wire

FILE: tb/tb_row_permutation_tracker.sv
// Testbench for row_permutation_tracker: directed item table, random items, predictor checks.
module tb_row_permutation_tracker;
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             bad;
        logic             fin;
    } result_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] tgt;
        logic [ADR_W-1:0] len;
        logic             lst;
        logic             known;
        logic [VAL_W-1:0] want_val;
        logic             want_bad;
        logic [ADR_W-1:0] cfg;
    } dir_row_t;

    // fields: kind, op, idx, tgt, len, lst, known, want_val, want_bad, cfg
    localparam int DIR_ROWS = 31;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_ITEM, OP_READ,    8'd0,   8'd0,   9'd1,   1'b0, 1'b1, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd255, 8'd0,   9'd1,   1'b0, 1'b1, 8'd255, 1'b0, 9'd0},
        '{ROW_ITEM, OP_SWAP,    8'd0,   8'd255, 9'd1,   1'b0, 1'b1, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd0,   8'd0,   9'd1,   1'b0, 1'b1, 8'd255, 1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd255, 8'd0,   9'd1,   1'b0, 1'b1, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_CLEAR,   8'd255, 8'd255, 9'd511, 1'b1, 1'b1, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd255, 8'd0,   9'd1,   1'b0, 1'b1, 8'd255, 1'b0, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd0,   8'd0,   9'd0,   1'b1, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd0,   8'd0,   9'd257, 1'b1, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd255, 8'd255, 9'd511, 1'b1, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd2,   8'd0,   9'd2,   1'b0, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd0,   8'd1,   9'd2,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd1,   8'd0,   9'd2,   1'b1, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd255, 8'd0,   9'd1,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_CFG,  OP_CLEAR,   8'd0,   8'd0,   9'd0,   1'b0, 1'b0, 8'd0,   1'b0, 9'd4},
        '{ROW_ITEM, OP_SWAP,    8'd4,   8'd0,   9'd1,   1'b0, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_SWAP,    8'd0,   8'd4,   9'd1,   1'b0, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_SWAP,    8'd3,   8'd0,   9'd1,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd4,   8'd0,   9'd1,   1'b0, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd0,   8'd0,   9'd5,   1'b0, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_CFG,  OP_CLEAR,   8'd0,   8'd0,   9'd0,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd0,   8'd0,   9'd1,   1'b0, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_SWAP,    8'd0,   8'd0,   9'd1,   1'b0, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd0,   8'd0,   9'd1,   1'b1, 1'b1, 8'd0,   1'b1, 9'd0},
        '{ROW_ITEM, OP_CLEAR,   8'd0,   8'd0,   9'd1,   1'b0, 1'b1, 8'd0,   1'b0, 9'd0},
        '{ROW_CFG,  OP_CLEAR,   8'd0,   8'd0,   9'd0,   1'b0, 1'b0, 8'd0,   1'b0, 9'd511},
        '{ROW_ITEM, OP_READ,    8'd255, 8'd0,   9'd1,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_COMPOSE, 8'd0,   8'd0,   9'd1,   1'b1, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_CFG,  OP_CLEAR,   8'd0,   8'd0,   9'd0,   1'b0, 1'b0, 8'd0,   1'b0, 9'd1},
        '{ROW_ITEM, OP_SWAP,    8'd0,   8'd0,   9'd1,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0},
        '{ROW_ITEM, OP_READ,    8'd0,   8'd0,   9'd1,   1'b0, 1'b0, 8'd0,   1'b0, 9'd0}
    };

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic [ADR_W-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic [1:0]       func       = '0;
    logic [IDX_W-1:0] index      = '0;
    logic [IDX_W-1:0] target     = '0;
    logic [ADR_W-1:0] sub_length = '0;
    logic             last       = 1'b0;
    logic             out_ready  = 1'b0;
    logic             cfg_ready;
    logic             in_ready;
    logic             out_valid;
    logic [VAL_W-1:0] read_value;
    logic             range_error;
    logic             done_res;

    logic [VAL_W-1:0] perm_rows   [MAX_ROWS_DEF];
    logic [VAL_W-1:0] compose_buf [MAX_ROWS_DEF];
    bit               buf_set     [MAX_ROWS_DEF];
    logic [ADR_W-1:0] cur_size = SIZE_RESET;
    result_t          pending_results [$];

    int idle_pct     = 7;
    int items_sent   = 0;
    int results_seen = 0;
    int flagged      = 0;
    int writebacks   = 0;
    int size_writes  = 0;
    int errors       = 0;

    row_permutation_tracker DUT (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
        .in_valid, .in_ready, .func, .index, .target, .sub_length, .last,
        .out_valid, .out_ready, .read_value, .range_error, .done_res
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #30ms;
        $display("row_permutation_tracker: mismatch");
        $finish;
    end

    function automatic int rows_in_use();
        return (cur_size > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(cur_size);
    endfunction

    function automatic bit compose_rejected(int idx, int tgt, int len);
        int size;
        size = rows_in_use();
        return len == 0 || len > size || idx >= len || tgt >= len;
    endfunction

    // a write-back may only copy buffer slots written since reset
    function automatic bit writeback_safe(int idx, int tgt, int len);
        if (compose_rejected(idx, tgt, len))
            return 1'b1;
        for (int k = 0; k < len; k++)
            if (k != idx && !buf_set[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_row();
        int size;
        size = rows_in_use();
        if (size > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(0, size - 1);
        return $urandom_range(0, 255);
    endfunction

    function automatic result_t track_op(op_t op, int idx, int tgt, int len, logic lst);
        result_t          r;
        int               size;
        int               base;
        logic [VAL_W-1:0] t;
        r = '{value: '0, bad: 1'b0, fin: 1'b1};
        size = rows_in_use();
        case (op)
            OP_CLEAR:
                for (int k = 0; k < size; k++)
                    perm_rows[k] = VAL_W'(k);
            OP_SWAP:
                if (idx >= size || tgt >= size)
                    r.bad = 1'b1;
                else
                begin
                    t = perm_rows[idx];
                    perm_rows[idx] = perm_rows[tgt];
                    perm_rows[tgt] = t;
                end
            OP_COMPOSE:
                if (compose_rejected(idx, tgt, len))
                    r.bad = 1'b1;
                else
                begin
                    base = size - len;
                    compose_buf[idx] = perm_rows[base + tgt];
                    buf_set[idx] = 1'b1;
                    if (lst)
                    begin
                        for (int k = 0; k < len; k++)
                            perm_rows[base + k] = compose_buf[k];
                        writebacks++;
                    end
                end
            default:
                if (idx >= size)
                    r.bad = 1'b1;
                else
                    r.value = perm_rows[idx];
        endcase
        return r;
    endfunction

    task automatic report_bad(input string what, input int got, input int want_v);
        errors++;
        $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want_v);
    endtask

    task automatic send_op(input op_t op, input int idx, input int tgt, input int len,
                           input logic lst, input bit known, input result_t want);
        result_t got;
        logic    lst_ok;
        lst_ok = lst && writeback_safe(idx, tgt, len);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        index      <= IDX_W'(idx);
        target     <= IDX_W'(tgt);
        sub_length <= ADR_W'(len);
        last       <= lst_ok;
        do
            @(posedge clk);
        while (!in_ready);
        got = track_op(op, idx, tgt, len, lst_ok);
        items_sent++;
        if (got.bad)
            flagged++;
        pending_results.push_back(known ? want : got);
    endtask

    // only written with the block drained and quiet
    task automatic set_rows(input logic [ADR_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_size = v;
        size_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge clk)
    begin : check_out
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_bad("result with nothing pending", 0, 0);
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (read_value !== want.value)
                    report_bad("read_value", int'(read_value), int'(want.value));
                if (range_error !== want.bad)
                    report_bad("range_error", int'(range_error), int'(want.bad));
                if (done_res !== want.fin)
                    report_bad("done_res", int'(done_res), int'(want.fin));
            end
        end
    end

    initial
    begin
        int               size;
        int               pick;
        int               lim;
        int               seq_len;
        int               bad_at;
        int               j;
        int               t;
        int               phase_end;
        int               slot_ord [MAX_ROWS_DEF];
        int               tgt_ord  [MAX_ROWS_DEF];
        logic [ADR_W-1:0] phase_size;
        result_t          none;
        none = '0;
        for (int k = 0; k < MAX_ROWS_DEF; k++)
        begin
            perm_rows[k] = VAL_W'(k);
            buf_set[k]   = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                set_rows(DIRECTED[r].cfg);
            else
                send_op(DIRECTED[r].op, int'(DIRECTED[r].idx), int'(DIRECTED[r].tgt),
                        int'(DIRECTED[r].len), DIRECTED[r].lst, DIRECTED[r].known,
                        '{value: DIRECTED[r].want_val, bad: DIRECTED[r].want_bad, fin: 1'b1});
        end

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:       phase_size = 9'd256;
                1:       phase_size = 9'd1;
                2:       phase_size = 9'd2;
                3:       phase_size = 9'd511;
                4:       phase_size = 9'd0;
                5:       phase_size = 9'd300;
                6:       phase_size = 9'd37;
                7:       phase_size = ADR_W'($urandom_range(0, 511));
                default: phase_size = ADR_W'($urandom_range(1, 256));
            endcase
            idle_pct = (p == 5) ? 0 : 7;
            set_rows(phase_size);
            phase_end = items_sent + 140;
            while (items_sent < phase_end)
            begin
                size = rows_in_use();
                pick = $urandom_range(0, 99);
                if (pick < 40 && size > 0)
                begin
                    lim = (size < 8) ? size : 8;
                    seq_len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, size)
                                                           : $urandom_range(1, lim);
                    for (int i = 0; i < seq_len; i++)
                    begin
                        slot_ord[i] = i;
                        tgt_ord[i]  = i;
                    end
                    for (int i = seq_len - 1; i > 0; i--)
                    begin
                        j = $urandom_range(0, i);
                        t = slot_ord[i]; slot_ord[i] = slot_ord[j]; slot_ord[j] = t;
                        j = $urandom_range(0, i);
                        t = tgt_ord[i]; tgt_ord[i] = tgt_ord[j]; tgt_ord[j] = t;
                    end
                    // sometimes not a permutation: repeated source rows
                    if ($urandom_range(0, 3) == 0)
                        for (int i = 0; i < seq_len; i++)
                            tgt_ord[i] = $urandom_range(0, seq_len - 1);
                    bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, seq_len - 1) : -1;
                    for (int i = 0; i < seq_len; i++)
                    begin
                        if (i == bad_at)
                            send_op(OP_COMPOSE, slot_ord[i], $urandom_range(0, 255),
                                    $urandom_range(0, 511), i == seq_len - 1, 1'b0, none);
                        else
                            send_op(OP_COMPOSE, slot_ord[i], tgt_ord[i], seq_len,
                                    i == seq_len - 1, 1'b0, none);
                    end
                end
                else if (pick < 60)
                    send_op(OP_SWAP, pick_row(), pick_row(), $urandom_range(0, 511),
                            1'($urandom_range(0, 1)), 1'b0, none);
                else if (pick < 85)
                    send_op(OP_READ, pick_row(), $urandom_range(0, 255), $urandom_range(0, 511),
                            1'($urandom_range(0, 1)), 1'b0, none);
                else if (pick < 90)
                    send_op(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 511), 1'($urandom_range(0, 1)), 1'b0, none);
                else
                    send_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 511),
                            1'($urandom_range(0, 1)), 1'b0, none);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("covered %0d items (%0d out of range) over %0d table size settings",
                 items_sent, flagged, size_writes);
        $display("%0d results compared, %0d compose write-backs into the table tail",
                 results_seen, writebacks);
        if (errors == 0)
            $display("row_permutation_tracker: match");
        else
            $display("row_permutation_tracker: mismatch");
        $finish;
    end

endmodule
